@@ src/vrpw_pkg.sv @@
// Shared widths and types for the windowed RMS and peak vibration detector.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package vrpw_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;               // accelerometer axis and level width
    localparam int ENERGY_W = 2 * SAMPLE_W;     // sum of three squares fits 32 bits
    localparam int SUM_W    = 48;               // window accumulator
    localparam int ROOT_W   = SUM_W / 2;        // square root of the widest radicand
    localparam int REM_W    = ROOT_W + 3;       // partial remainder of the root unit

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [SAMPLE_W-1:0] level_t;
    typedef logic        [ENERGY_W-1:0] energy_t;
    typedef logic        [SUM_W-1:0]    sum_t;
    typedef logic        [ROOT_W-1:0]   root_t;

endpackage

`default_nettype wire

@@ src/vrpw_in_if.sv @@
// Sample channel: one three-axis accelerometer sample per beat.
// Depends on vrpw_pkg for the field types.
`default_nettype none

interface vrpw_in_if;
    import vrpw_pkg::*;

    logic    valid;
    logic    ready;
    sample_t accel_x;
    sample_t accel_y;
    sample_t accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

`default_nettype wire

@@ src/vrpw_out_if.sv @@
// Result channel: RMS and peak vibration of one closed window per beat.
// Depends on vrpw_pkg for the field types.
`default_nettype none

interface vrpw_out_if;
    import vrpw_pkg::*;

    logic   valid;
    logic   ready;
    level_t rms_level;
    level_t peak_level;

    modport source (output valid, output rms_level, output peak_level, input ready);
    modport sink   (input valid, input rms_level, input peak_level, output ready);
endinterface

`default_nettype wire

@@ src/vrpw_square.sv @@
// Bit-serial squarer: shift-and-add, one multiplier bit per cycle.
// Depends on vrpw_pkg for widths.
`default_nettype none

module vrpw_square (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       start,
    input  wire [vrpw_pkg::SAMPLE_W-1:0] opnd,
    output logic                      done,
    output logic [vrpw_pkg::ENERGY_W-1:0] product
);
    import vrpw_pkg::*;

    localparam int STEP_W = $clog2(SAMPLE_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SAMPLE_W - 1);

    energy_t           mcand_reg;
    level_t            mplier_reg;
    energy_t           prod_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    // One partial product per cycle, lowest multiplier bit first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcand_reg  <= '0;
            mplier_reg <= '0;
            prod_reg   <= '0;
            step_reg   <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                mcand_reg  <= {{(ENERGY_W-SAMPLE_W){1'b0}}, opnd};
                mplier_reg <= opnd;
                prod_reg   <= '0;
                step_reg   <= '0;
                busy_reg   <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (mplier_reg[0])
                begin
                    prod_reg <= prod_reg + mcand_reg;
                end
                mcand_reg  <= {mcand_reg[ENERGY_W-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[SAMPLE_W-1:1]};
                step_reg   <= step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

`default_nettype wire

@@ src/vrpw_sqrt.sv @@
// Digit-serial integer square root: two radicand bits in, one root bit out per cycle.
// Depends on vrpw_pkg for widths.
`default_nettype none

module vrpw_sqrt (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    input  wire [vrpw_pkg::SUM_W-1:0] radicand,
    output logic                    done,
    output logic [vrpw_pkg::ROOT_W-1:0] root
);
    import vrpw_pkg::*;

    localparam int STEP_W = $clog2(ROOT_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ROOT_W - 1);

    sum_t              rad_reg;
    logic [REM_W-1:0]  rem_reg;
    root_t             root_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic              fits;

    // Bring down the next radicand digit and try the next root bit
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], rad_reg[SUM_W-1:SUM_W-2]};
        trial     = {1'b0, root_reg, 2'b01};
        fits      = (rem_shift >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rad_reg  <= {rad_reg[SUM_W-3:0], 2'b00};
                rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
                root_reg <= {root_reg[ROOT_W-2:0], fits};
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

@@ src/vrpw_div.sv @@
// Bit-serial restoring divider: window sum over sample count, one quotient bit per cycle.
// Depends on vrpw_pkg for widths.
`default_nettype none

module vrpw_div #(
    parameter int DIV_W = 16
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    input  wire [vrpw_pkg::SUM_W-1:0] dividend,
    input  wire [DIV_W-1:0]         divisor,
    output logic                    done,
    output logic [vrpw_pkg::SUM_W-1:0] quotient
);
    import vrpw_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    sum_t              quo_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  dsr_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIV_W:0]    rem_shift;
    logic [DIV_W:0]    diff;
    logic              fits;

    // Shift in the next dividend bit and subtract where the divisor fits
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[SUM_W-1]};
        diff      = rem_shift - {1'b0, dsr_reg};
        fits      = (rem_shift >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
                quo_reg  <= {quo_reg[SUM_W-2:0], fits};
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

@@ src/vibration_rms_peak_window.sv @@
// Windowed RMS and peak vibration detector, top level.
// Depends on vrpw_pkg, vrpw_in_if, vrpw_out_if, vrpw_square, vrpw_sqrt and vrpw_div.
//
// Usage:
//   sample_in carries one accelerometer sample (accel_x/y/z, signed) per beat.
//   result_out carries rms_level and peak_level once per closed window.
//   cfg_wr_en/cfg_wr_data write window_samples (zero closes after every sample).
// Sequencing:
//   One sample is worked at a time. The shared bit-serial squarer (16 steps
//   per square, three axis squares plus the vibration square) and the
//   2-bit-per-cycle root unit (24 steps) work it in turn; ready stays low
//   until that sample is through. A closing sample adds the 48-step serial
//   divider and a second root pass; its result beat goes valid, and ready
//   comes back, in the same cycle.
// Reset: count, sum, peak and window_samples clear to zero; no beat is pending.
// Stall: the result sits in an output register. While it waits, the next
//   samples are still accepted and worked; only a second closing window waits
//   for the register to drain before the block takes another sample.
`default_nettype none

module vibration_rms_peak_window #(
    parameter int COUNT_BITS   = 16,
    parameter int ONE_G_COUNTS = 16384
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_wr_en,
    input  wire [vrpw_pkg::SAMPLE_W-1:0] cfg_wr_data,
    vrpw_in_if.sink                      sample_in,
    vrpw_out_if.source                   result_out
);
    import vrpw_pkg::*;

    localparam int CMP_W = (COUNT_BITS > SAMPLE_W) ? COUNT_BITS : SAMPLE_W;
    localparam level_t ONE_G = SAMPLE_W'(ONE_G_COUNTS);
    localparam logic [1:0] AXIS_LAST = 2'd2;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SQ   = 7'b0000010,
        S_ROOT = 7'b0000100,
        S_VSQ  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_RMS  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    function automatic level_t abs16(input sample_t v);
        abs16 = v[SAMPLE_W-1] ? level_t'(~v + 1'b1) : level_t'(v);
    endfunction

    state_t                state_reg;
    logic [1:0]            axis_reg;
    logic [3*SAMPLE_W-1:0] abs_shift_reg;
    energy_t               energy_reg;
    sum_t                  sqrt_opnd_reg;
    logic                  mul_start_reg;
    logic                  sqrt_start_reg;
    logic                  div_start_reg;
    level_t                window_samples_reg;
    logic [COUNT_BITS-1:0] count_reg;
    sum_t                  sum_reg;
    level_t                peak_reg;
    level_t                vib_reg;
    level_t                rms_hold_reg;
    level_t                rms_out_reg;
    level_t                peak_out_reg;
    logic                  out_valid_reg;

    logic                  mul_done;
    energy_t               mul_product;
    logic                  sqrt_done;
    root_t                 sqrt_root;
    logic                  div_done;
    sum_t                  div_quotient;

    energy_t               energy_next;
    level_t                mag;
    level_t                vib_next;
    logic [SUM_W:0]        sum_add;
    sum_t                  sum_next;
    logic [COUNT_BITS-1:0] count_next;
    level_t                peak_next;
    logic                  window_close;
    logic                  out_free;

    // Serial arithmetic units
    vrpw_square u_square (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .opnd    (abs_shift_reg[SAMPLE_W-1:0]),
        .done    (mul_done),
        .product (mul_product)
    );

    vrpw_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start_reg),
        .radicand (sqrt_opnd_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    vrpw_div #(
        .DIV_W (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Per-sample arithmetic and window bookkeeping
    always_comb
    begin
        energy_next  = energy_reg + mul_product;
        mag          = sqrt_root[SAMPLE_W-1:0];
        vib_next     = (mag >= ONE_G) ? (mag - ONE_G) : (ONE_G - mag);
        sum_add      = {1'b0, sum_reg} + {{(SUM_W+1-ENERGY_W){1'b0}}, mul_product};
        sum_next     = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        count_next   = (count_reg == '1) ? count_reg : (count_reg + 1'b1);
        peak_next    = (vib_reg > peak_reg) ? vib_reg : peak_reg;
        window_close = (CMP_W'(count_next) >= CMP_W'(window_samples_reg))
                       || (count_next == '1);
        out_free     = !out_valid_reg || result_out.ready;
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            axis_reg           <= '0;
            abs_shift_reg      <= '0;
            energy_reg         <= '0;
            sqrt_opnd_reg      <= '0;
            mul_start_reg      <= 1'b0;
            sqrt_start_reg     <= 1'b0;
            div_start_reg      <= 1'b0;
            window_samples_reg <= '0;
            count_reg          <= '0;
            sum_reg            <= '0;
            peak_reg           <= '0;
            vib_reg            <= '0;
            rms_hold_reg       <= '0;
            rms_out_reg        <= '0;
            peak_out_reg       <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            mul_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            div_start_reg  <= 1'b0;

            if (cfg_wr_en)
            begin
                window_samples_reg <= cfg_wr_data;
            end

            // drained beat; a load in S_OUT takes precedence below
            if (out_valid_reg && result_out.ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (sample_in.valid)
                    begin
                        abs_shift_reg <= {abs16(sample_in.accel_z), abs16(sample_in.accel_y),
                                          abs16(sample_in.accel_x)};
                        energy_reg    <= '0;
                        axis_reg      <= '0;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_SQ;
                    end
                end

                // Square and sum the three axes, one after the other
                S_SQ:
                begin
                    if (mul_done)
                    begin
                        energy_reg <= energy_next;
                        if (axis_reg == AXIS_LAST)
                        begin
                            sqrt_opnd_reg  <= {{(SUM_W-ENERGY_W){1'b0}}, energy_next};
                            sqrt_start_reg <= 1'b1;
                            state_reg      <= S_ROOT;
                        end
                        else
                        begin
                            axis_reg      <= axis_reg + 1'b1;
                            abs_shift_reg <= {{SAMPLE_W{1'b0}},
                                              abs_shift_reg[3*SAMPLE_W-1:SAMPLE_W]};
                            mul_start_reg <= 1'b1;
                        end
                    end
                end

                // Magnitude ready: take vibration and square it
                S_ROOT:
                begin
                    if (sqrt_done)
                    begin
                        vib_reg       <= vib_next;
                        abs_shift_reg <= {{(2*SAMPLE_W){1'b0}}, vib_next};
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_VSQ;
                    end
                end

                // Accumulate and decide whether the window closes
                S_VSQ:
                begin
                    if (mul_done)
                    begin
                        sum_reg   <= sum_next;
                        count_reg <= count_next;
                        peak_reg  <= peak_next;
                        if (window_close)
                        begin
                            div_start_reg <= 1'b1;
                            state_reg     <= S_DIV;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        sqrt_opnd_reg  <= div_quotient;
                        sqrt_start_reg <= 1'b1;
                        state_reg      <= S_RMS;
                    end
                end

                S_RMS:
                begin
                    if (sqrt_done)
                    begin
                        rms_hold_reg <= sqrt_root[SAMPLE_W-1:0];
                        state_reg    <= S_OUT;
                    end
                end

                // Hand the result to the output register, then start a new window
                S_OUT:
                begin
                    if (out_free)
                    begin
                        rms_out_reg   <= rms_hold_reg;
                        peak_out_reg  <= peak_reg;
                        out_valid_reg <= 1'b1;
                        count_reg     <= '0;
                        sum_reg       <= '0;
                        peak_reg      <= '0;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign sample_in.ready       = (state_reg == S_IDLE);
    assign result_out.valid      = out_valid_reg;
    assign result_out.rms_level  = rms_out_reg;
    assign result_out.peak_level = peak_out_reg;

endmodule

`default_nettype wire

@@ tb/vrpw_window_checker.sv @@
// Scoreboard for the windowed RMS and peak vibration detector: tracks the window
// state, predicts each result beat and compares it with what the block sends.
// Depends on vrpw_pkg, vrpw_in_if and vrpw_out_if.
`timescale 1ns / 1ps

module vrpw_window_checker #(
    parameter int COUNT_BITS   = 16,
    parameter int ONE_G_COUNTS = 16384
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_wr_en,
    input  wire [vrpw_pkg::SAMPLE_W-1:0] cfg_wr_data,
    vrpw_in_if                           sample_mon,
    vrpw_out_if                          result_mon,
    output int                           mismatch_count,
    output int                           results_owed
);
    import vrpw_pkg::*;

    localparam longint unsigned SUM_LIMIT   = (64'd1 << SUM_W) - 64'd1;
    localparam longint unsigned COUNT_LIMIT = (64'd1 << COUNT_BITS) - 64'd1;

    typedef struct packed {
        level_t rms;
        level_t peak;
    } window_result_t;

    // Predicted window state and register copy
    longint unsigned window_len;
    longint unsigned count_in_window;
    longint unsigned energy_sum;
    level_t          peak_so_far;
    window_result_t  pending_windows[$];

    // Floor square root, one result bit per pass from the top down
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // |floor(|a|) - 1 g| for one three-axis sample
    function automatic level_t vibration_of(sample_t x, sample_t y, sample_t z);
        longint ax;
        longint ay;
        longint az;
        longint unsigned magnitude;
        longint unsigned one_g;
        ax = longint'(x);
        ay = longint'(y);
        az = longint'(z);
        magnitude = floor_root(64'(ax * ax + ay * ay + az * az));
        one_g = 64'(ONE_G_COUNTS);
        if (magnitude >= one_g)
            return level_t'(magnitude - one_g);
        return level_t'(one_g - magnitude);
    endfunction

    // Watch both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        level_t          vib;
        longint unsigned vib_sq;
        longint unsigned divisor;
        window_result_t  want;
        window_result_t  got;
        if (!rst_n)
        begin
            window_len      = 0;
            count_in_window = 0;
            energy_sum      = 0;
            peak_so_far     = '0;
            pending_windows.delete();
            mismatch_count = 0;
            results_owed   = 0;
        end
        else
        begin
            if (cfg_wr_en)
                window_len = 64'(cfg_wr_data);

            // result beat against the oldest open prediction
            if (result_mon.valid && result_mon.ready)
            begin
                got.rms  = result_mon.rms_level;
                got.peak = result_mon.peak_level;
                if (pending_windows.size() == 0)
                begin
                    $error("result beat with nothing expected: rms_level %0d, peak_level %0d",
                           got.rms, got.peak);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_windows.pop_front();
                    if (got.rms !== want.rms)
                    begin
                        $error("rms_level: expected %0d, got %0d", want.rms, got.rms);
                        mismatch_count++;
                    end
                    if (got.peak !== want.peak)
                    begin
                        $error("peak_level: expected %0d, got %0d", want.peak, got.peak);
                        mismatch_count++;
                    end
                end
            end

            // sample beat: accumulate, close the window when it is full
            if (sample_mon.valid && sample_mon.ready)
            begin
                vib = vibration_of(sample_mon.accel_x, sample_mon.accel_y, sample_mon.accel_z);
                vib_sq = {48'd0, vib};
                vib_sq = vib_sq * vib_sq;
                if (energy_sum > SUM_LIMIT - vib_sq)
                    energy_sum = SUM_LIMIT;
                else
                    energy_sum += vib_sq;
                if (count_in_window < COUNT_LIMIT)
                    count_in_window++;
                if (vib > peak_so_far)
                    peak_so_far = vib;
                if (count_in_window >= window_len || count_in_window >= COUNT_LIMIT)
                begin
                    divisor = (count_in_window != 0) ? count_in_window : 64'd1;
                    want.rms  = level_t'(floor_root(energy_sum / divisor));
                    want.peak = peak_so_far;
                    pending_windows.push_back(want);
                    count_in_window = 0;
                    energy_sum      = 0;
                    peak_so_far     = '0;
                end
            end

            results_owed = pending_windows.size();
        end
    end

endmodule

@@ tb/vibration_rms_peak_window_test.sv @@
// Top of the vibration detector testbench: clock, reset, sample and register
// stimulus, result back-pressure and the verdict.
// Depends on vrpw_pkg, both channel interfaces, the block and vrpw_window_checker.
`timescale 1ns / 1ps

module vibration_rms_peak_window_test;
    import vrpw_pkg::*;

    localparam int SETTLE_CYCLES = 250;     // one non-closing sample still in flight
    localparam int PHASES        = 10;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [SAMPLE_W-1:0] cfg_wr_data;
    int               mismatch_count;
    int               results_owed;
    int               sender_idle_pct;
    int               receiver_stall_pct;
    sample_t          cur_x;
    sample_t          cur_y;
    sample_t          cur_z;

    // Window plan for the random part; mode picks the sender idling and receiver stall pattern
    int unsigned plan_len[PHASES]   = '{1, 0, 4, 16, 65535, 2, 3, 7, 0, 1};
    int          plan_items[PHASES] = '{180, 180, 180, 180, 50, 180, 180, 180, 180, 180};
    int          idle_by_mode[4]    = '{0, 56, 0, 33};
    int          stall_by_mode[4]   = '{0, 0, 56, 33};
    sample_t     corner_vals[6]     = '{-32768, 32767, 0, -1, 1, 16384};

    vrpw_in_if  sample_ch();
    vrpw_out_if result_ch();

    vibration_rms_peak_window dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample_in   (sample_ch),
        .result_out  (result_ch)
    );

    vrpw_window_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .sample_mon     (sample_ch),
        .result_mon     (result_ch),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always #5 clk = ~clk;

    // Result back-pressure
    always @(negedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // One sample beat; valid is left high so the next beat may follow directly
    task automatic send_sample(sample_t x, sample_t y, sample_t z);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.accel_x <= x;
        sample_ch.accel_y <= y;
        sample_ch.accel_z <= z;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop sending and wait for every closed window to come out
    task automatic drain();
        sample_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (results_owed != 0);
    endtask

    // Register write with the block idle
    task automatic set_window(int unsigned len);
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len[SAMPLE_W-1:0];
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Random sample: raw noise, gravity plus noise, corner values or a repeat
    task automatic send_random();
        int      pick;
        int      amp;
        int      g_axis;
        sample_t axes[3];
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            cur_x = sample_t'($urandom);
            cur_y = sample_t'($urandom);
            cur_z = sample_t'($urandom);
        end
        else if (pick < 80)
        begin
            amp = 1 << $urandom_range(13);
            for (int k = 0; k < 3; k++)
                axes[k] = sample_t'($urandom_range(2 * amp) - amp);
            g_axis = $urandom_range(2);
            axes[g_axis] = sample_t'(axes[g_axis] + ($urandom_range(1) ? 16384 : -16384));
            cur_x = axes[0];
            cur_y = axes[1];
            cur_z = axes[2];
        end
        else if (pick < 90)
        begin
            cur_x = corner_vals[$urandom_range(5)];
            cur_y = corner_vals[$urandom_range(5)];
            cur_z = corner_vals[$urandom_range(5)];
        end
        send_sample(cur_x, cur_y, cur_z);
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        sample_ch.valid    = 1'b0;
        sample_ch.accel_x  = '0;
        sample_ch.accel_y  = '0;
        sample_ch.accel_z  = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        cur_x = '0;
        cur_y = '0;
        cur_z = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero window: every sample closes; axis extremes, vibration zero
        set_window(0);
        send_sample(0, 0, 0);
        send_sample(16384, 0, 0);
        send_sample(-32768, -32768, -32768);
        send_sample(32767, 32767, 32767);
        send_sample(0, 0, -16384);
        send_sample(-32768, 0, 0);
        send_sample(1, -1, 1);
        send_sample(0, 0, 16385);

        // short window, repeated sample leaves the peak alone
        set_window(3);
        send_sample(100, 200, 16000);
        send_sample(100, 200, 16000);
        send_sample(100, 200, 16000);
        send_sample(0, 16384, 1);
        send_sample(-5000, 3000, -20000);
        send_sample(32767, -32768, 0);

        // longest window, then cut short by a smaller setting
        set_window(65535);
        send_sample(-32768, 32767, -32768);
        send_sample(12000, -9000, 4000);
        send_sample(0, 0, 0);
        send_sample(-16384, 0, 0);
        set_window(1);
        send_sample(300, -300, 16500);
        set_window(2);
        send_sample(-1, -1, -1);
        send_sample(20000, 20000, -20000);

        // random phases
        for (int p = 0; p < PHASES; p++)
        begin
            set_window(plan_len[p]);
            sender_idle_pct    = idle_by_mode[p % 4];
            receiver_stall_pct = stall_by_mode[p % 4];
            for (int i = 0; i < plan_items[p]; i++)
            begin
                send_random();
                if ($urandom_range(63) == 0)
                    drain();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hang guard
    initial
    begin
        #20000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
